@@ rtl/core/rts_pkg.sv @@
package rts_pkg;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned ID_W      = 16;
    localparam int unsigned IVL_W     = 32;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned MAX_FIRES = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_REMOWN = 3'd3,
        CMD_EXISTS = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_OK    = 2'd1,
        KIND_FAIL  = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_ACT,
        ST_FIRE_RD,
        ST_FIRE_WR,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/repeating_timer_scheduler.sv @@
// Repeating timer scheduler.
// Slave channel s_*: one command item per handshake (tick, add, remove one,
// remove owner, exists). Master channel m_*: result items, tlast on the final
// result of each command.
// The timer table sits in one synchronous memory (one read, one write port,
// registered read data); the valid, done and owner-match bits are flip-flops.
// Non-tick commands: one pass over the table, then the result; the next
// command can be accepted once the result is taken.
// Tick: each firing takes one scan pass to find the
// earliest expired timer, then a read-modify-write and output of the fire
// result; up to 16 firings, then a tick-done result.
// A command is accepted only while idle. Results wait in an output register
// while m_tready is low; the block holds until each is taken.
// Reset (aresetn low, synchronous) clears all valid bits and the controller;
// table contents are not cleared.
module repeating_timer_scheduler #(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: command[2:0], now_ms[50:3], owner_id[66:51], timer_id[82:67],
    // interval_ms[114:83], repeat_count[131:115], zero fill to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: kind[1:0], fired_owner[17:2], fired_timer[33:18],
    // remaining[50:34], zero fill to 56
    output logic [55:0]  m_tdata,
    output logic         m_tlast
);
    localparam int unsigned SW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned CW  = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned FIRE_CAP = (TIMER_SLOTS < rts_pkg::MAX_FIRES)
                                       ? TIMER_SLOTS : rts_pkg::MAX_FIRES;

    typedef struct packed {
        logic [rts_pkg::ID_W-1:0]   owner;
        logic [rts_pkg::ID_W-1:0]   timer;
        logic [rts_pkg::IVL_W-1:0]  ivl;
        logic signed [rts_pkg::CNT_W-1:0] cnt;
        logic [rts_pkg::TIME_W-1:0] dl;
    } entry_t;

    // table memory
    entry_t mem [TIMER_SLOTS];
    entry_t rd_q;
    logic [SW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    entry_t        wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // command register
    logic [2:0] cmd_reg;
    logic [rts_pkg::TIME_W-1:0] now_reg;
    logic [rts_pkg::ID_W-1:0] own_reg, tim_reg;
    logic [rts_pkg::IVL_W-1:0] ivl_reg;
    logic signed [rts_pkg::CNT_W-1:0] cnt_reg;

    rts_pkg::state_t state_reg, state_next;
    logic [SW-1:0] idx_reg;      // address issued
    logic [SW-1:0] cidx_reg;     // address of rd_q
    logic [TIMER_SLOTS-1:0] valid_reg, done_reg;
    logic [TIMER_SLOTS-1:0] own_match_reg;
    logic found_reg, free_found_reg, best_reg;
    logic [SW-1:0] hit_reg, free_reg, best_idx_reg;
    logic [rts_pkg::TIME_W-1:0] best_dl_reg;
    logic [CW-1:0] nfire_reg;
    logic [1:0] okind_reg;
    logic [rts_pkg::ID_W-1:0] oown_reg, otim_reg;
    logic [rts_pkg::CNT_W-1:0] orem_reg;
    logic olast_reg;

    wire s_acc = s_tvalid && s_tready;
    wire m_acc = m_tvalid && m_tready;
    wire cur_v = valid_reg[cidx_reg];
    wire last_addr = (idx_reg == SW'(TIMER_SLOTS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rts_pkg::ST_IDLE:      if (s_acc) state_next = rts_pkg::ST_SCAN;
            rts_pkg::ST_SCAN:      if (last_addr) state_next = rts_pkg::ST_SCAN_LAST;
            rts_pkg::ST_SCAN_LAST: state_next = rts_pkg::ST_ACT;
            rts_pkg::ST_ACT: begin
                if (cmd_reg == rts_pkg::CMD_TICK && best_reg &&
                    nfire_reg != CW'(FIRE_CAP)) begin
                    state_next = rts_pkg::ST_FIRE_RD;
                end else begin
                    state_next = rts_pkg::ST_OUT;
                end
            end
            rts_pkg::ST_FIRE_RD:   state_next = rts_pkg::ST_FIRE_WR;
            rts_pkg::ST_FIRE_WR:   state_next = rts_pkg::ST_OUT;
            rts_pkg::ST_OUT: begin
                if (m_acc) state_next = olast_reg ? rts_pkg::ST_IDLE : rts_pkg::ST_SCAN;
            end
            default:               state_next = rts_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    logic [rts_pkg::TIME_W:0] arm_sum;
    logic [rts_pkg::TIME_W-1:0] arm_dl;
    logic signed [rts_pkg::CNT_W-1:0] dec_cnt;
    always_comb begin
        s_tready = (state_reg == rts_pkg::ST_IDLE);
        m_tvalid = (state_reg == rts_pkg::ST_OUT);
        m_tlast  = olast_reg;
        m_tdata  = {5'd0, orem_reg, otim_reg, oown_reg, okind_reg};
        rd_addr  = (state_reg == rts_pkg::ST_ACT || state_reg == rts_pkg::ST_FIRE_RD)
                   ? best_idx_reg : idx_reg;
        arm_sum  = {1'b0, now_reg} + {{(rts_pkg::TIME_W + 1 - rts_pkg::IVL_W){1'b0}},
                   (state_reg == rts_pkg::ST_FIRE_WR) ? rd_q.ivl : ivl_reg};
        arm_dl   = arm_sum[rts_pkg::TIME_W] ? rts_pkg::TIME_MAX
                                           : arm_sum[rts_pkg::TIME_W-1:0];
        dec_cnt  = ($signed(rd_q.cnt) > 0) ? rd_q.cnt - 17'sd1 : rd_q.cnt;
        wr_en    = 1'b0;
        wr_addr  = free_reg;
        wr_data  = '{owner: own_reg, timer: tim_reg, ivl: ivl_reg, cnt: cnt_reg, dl: arm_dl};
        if (state_reg == rts_pkg::ST_ACT && cmd_reg == rts_pkg::CMD_ADD &&
            !found_reg && free_found_reg) begin
            wr_en = 1'b1;
        end
        if (state_reg == rts_pkg::ST_FIRE_WR) begin
            wr_en   = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = '{owner: rd_q.owner, timer: rd_q.timer, ivl: rd_q.ivl,
                        cnt: dec_cnt, dl: arm_dl};
        end
    end

    wire scanning = (state_reg == rts_pkg::ST_SCAN && idx_reg != '0) ||
                    (state_reg == rts_pkg::ST_SCAN_LAST);
    wire idx_zero_first = (state_reg == rts_pkg::ST_SCAN && idx_reg == '0);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= s_tdata[2:0];
            now_reg <= s_tdata[50:3];
            own_reg <= s_tdata[66:51];
            tim_reg <= s_tdata[82:67];
            ivl_reg <= s_tdata[114:83];
            cnt_reg <= s_tdata[131:115];
        end
        cidx_reg <= idx_reg;
        if (idx_zero_first) begin
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_reg <= 1'b0;
        end
        if (scanning) begin
            if (cur_v && rd_q.owner == own_reg && rd_q.timer == tim_reg && !found_reg) begin
                found_reg <= 1'b1;
                hit_reg <= cidx_reg;
            end
            if (!cur_v && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_reg <= cidx_reg;
            end
            if (cur_v && !done_reg[cidx_reg] && rd_q.dl <= now_reg &&
                (!best_reg || rd_q.dl < best_dl_reg)) begin
                best_reg <= 1'b1;
                best_idx_reg <= cidx_reg;
                best_dl_reg <= rd_q.dl;
            end
        end
        if (state_reg == rts_pkg::ST_ACT) begin
            oown_reg <= own_reg;
            otim_reg <= tim_reg;
            orem_reg <= '0;
            olast_reg <= 1'b1;
            okind_reg <= rts_pkg::KIND_FAIL;
            case (cmd_reg)
                rts_pkg::CMD_TICK: begin
                    okind_reg <= rts_pkg::KIND_DONE;
                    oown_reg <= '0;
                    otim_reg <= '0;
                end
                rts_pkg::CMD_ADD:
                    if (found_reg || free_found_reg) okind_reg <= rts_pkg::KIND_OK;
                rts_pkg::CMD_REMOVE, rts_pkg::CMD_EXISTS:
                    if (found_reg) okind_reg <= rts_pkg::KIND_OK;
                rts_pkg::CMD_REMOWN:
                    if (|(valid_reg & own_match_reg)) okind_reg <= rts_pkg::KIND_OK;
                default: okind_reg <= rts_pkg::KIND_FAIL;
            endcase
        end
        if (state_reg == rts_pkg::ST_FIRE_WR) begin
            okind_reg <= rts_pkg::KIND_FIRED;
            oown_reg <= rd_q.owner;
            otim_reg <= rd_q.timer;
            orem_reg <= dec_cnt;
            olast_reg <= 1'b0;
        end
    end

    // owner match bits, gathered during the scan
    always_ff @(posedge aclk) begin
        if (scanning) own_match_reg[cidx_reg] <= (rd_q.owner == own_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rts_pkg::ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            done_reg  <= '0;
            nfire_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rts_pkg::ST_SCAN && !last_addr) idx_reg <= idx_reg + 1'b1;
            else if (state_reg != rts_pkg::ST_SCAN) idx_reg <= '0;
            if (s_acc) begin
                done_reg  <= '0;
                nfire_reg <= '0;
            end
            if (state_reg == rts_pkg::ST_ACT) begin
                case (cmd_reg)
                    rts_pkg::CMD_ADD:
                        if (!found_reg && free_found_reg) valid_reg[free_reg] <= 1'b1;
                    rts_pkg::CMD_REMOVE:
                        if (found_reg) valid_reg[hit_reg] <= 1'b0;
                    rts_pkg::CMD_REMOWN:
                        valid_reg <= valid_reg & ~own_match_reg;
                    default: ;
                endcase
            end
            if (state_reg == rts_pkg::ST_FIRE_WR) begin
                done_reg[best_idx_reg] <= 1'b1;
                nfire_reg <= nfire_reg + 1'b1;
                if (dec_cnt == '0) valid_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/rts_checker.sv @@
module rts_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata,
    input logic         m_tlast
);
    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");

    // no command taken while results are pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && m_tvalid))
        else $error("input accepted while result pending");

    // fire results never close a command; tick-done always does
    a_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> !m_tlast)
        else $error("fire result marked last");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd3 |-> m_tlast && m_tdata[33:2] == 32'd0)
        else $error("bad tick-done result");

    // non-fire results carry zero remaining count
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[50:34] == 17'd0)
        else $error("remaining set on non-fire result");
endmodule

bind repeating_timer_scheduler rts_checker u_rts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
